/* rtl/gasp_pkg.sv */
`timescale 1ns / 1ps

package gasp_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;

    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int AW     = XW + YW;                          // cell address {y, x}
    localparam int DEPTH  = 2 ** AW;
    localparam int CW     = AW + 1;                           // open list count
    localparam int DW     = $clog2(GRID_WIDTH + GRID_HEIGHT - 1);
    localparam int COST_W = 12;
    localparam int PRIO_W = 13;
    localparam int DIR_W  = 3;
    localparam int CELL_W = COST_W + PRIO_W + DIR_W + 2;

    typedef logic [XW-1:0] gx_t;
    typedef logic [YW-1:0] gy_t;
    typedef logic [AW-1:0] addr_t;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [PRIO_W-1:0] prio;
        dir_t              parent;
        logic              open;
        logic              visited;
    } cell_t;

    typedef struct packed {
        logic          ok;
        gx_t           x;
        gy_t           y;
        logic [DW-1:0] manh;
    } step_t;

    typedef enum logic [4:0] {
        ST_WIPE,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_NF_C,
        ST_NF_CW,
        ST_NF_R,
        ST_NF_RW,
        ST_NF_END,
        ST_CHECK,
        ST_INIT,
        ST_SCAN,
        ST_POP_RD,
        ST_POP_WR,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_DONE
    } state_t;

    // ring offsets as {minus, plus}; the first four are the step directions
    function automatic logic [1:0] ring_dx(input logic [2:0] i);
        logic [1:0] r;
        case (i)
            3'd2, 3'd4, 3'd6: r = 2'b10;
            3'd3, 3'd5, 3'd7: r = 2'b01;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ring_dy(input logic [2:0] i);
        logic [1:0] r;
        case (i)
            3'd0, 3'd4, 3'd5: r = 2'b10;
            3'd1, 3'd6, 3'd7: r = 2'b01;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    // side of the parent as seen from a child reached by step k
    function automatic dir_t back_dir(input logic [1:0] k);
        dir_t d;
        case (k)
            2'd0:    d = DIR_DOWN;
            2'd1:    d = DIR_UP;
            2'd2:    d = DIR_RIGHT;
            default: d = DIR_LEFT;
        endcase
        return d;
    endfunction

endpackage

/* rtl/gasp_if.sv */
`timescale 1ns / 1ps

interface gasp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] goal_x;
    logic [7:0] goal_y;
    logic       obstacle;

    modport source (output valid, mode, cell_x, cell_y, goal_x, goal_y, obstacle,
                    input ready);
    modport sink   (input valid, mode, cell_x, cell_y, goal_x, goal_y, obstacle,
                    output ready);
endinterface

interface gasp_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  resolved_x;
    logic [7:0]  resolved_y;
    logic [11:0] cost;
    logic [2:0]  parent_dir;
    logic        visited;

    modport source (output valid, found, resolved_x, resolved_y, cost, parent_dir, visited,
                    input ready);
    modport sink   (input valid, found, resolved_x, resolved_y, cost, parent_dir, visited,
                    output ready);
endinterface

/* rtl/grid_astar_path_search_unit.sv */
`timescale 1ns / 1ps
// Flow: a search clears the cell store, moves blocked endpoints to a free ring cell, then per
// expansion scans the open list, pops the best entry and checks its four neighbors.
// Throughput: one item at a time; a search is bound by the linear open-list scan, one entry
// per cycle through the open-list and cell memories (one read port each).
// Reset: control clears at once, then a sweep over all DEPTH addresses (1024 at 32x32) clears the
// obstacle map and cell store while no item is accepted.
module grid_astar_path_search_unit
    import gasp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gasp_req_if.sink   req,
    gasp_rsp_if.source rsp
);

    // ---------------- memories ----------------
    logic  obs_we, obs_wdata, obs_rdata;
    addr_t obs_waddr, obs_raddr;
    logic  cell_we;
    addr_t cell_waddr, cell_raddr;
    cell_t cell_wdata, cell_rdata;
    logic [CELL_W-1:0] cell_rbits;
    logic  open_we;
    addr_t open_waddr, open_raddr, open_wdata, open_rdata;

    gasp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_obs (
        .clk(clk), .we(obs_we), .waddr(obs_waddr), .wdata(obs_wdata),
        .raddr(obs_raddr), .rdata(obs_rdata)
    );

    gasp_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cell (
        .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rbits)
    );
    assign cell_rdata = cell_t'(cell_rbits);

    gasp_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_open (
        .clk(clk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
        .raddr(open_raddr), .rdata(open_rdata)
    );

    // ---------------- registers ----------------
    state_t            state_reg, state_next;
    addr_t             clr_reg, clr_next;
    gx_t               sx_reg, sx_next, gx_reg, gx_next, best_x_reg, best_x_next;
    gy_t               sy_reg, sy_next, gy_reg, gy_next, best_y_reg, best_y_next;
    logic [DW-1:0]     best_d_reg, best_d_next;
    logic              pass_reg, pass_next, have_reg, have_next;
    logic              blk_s_reg, blk_s_next, blk_g_reg, blk_g_next;
    logic [2:0]        ring_reg, ring_next;
    logic [CW-1:0]     count_reg, count_next, si_reg, si_next;
    logic              v1_reg, v1_next, v2_reg, v2_next;
    addr_t             idx1_reg, idx1_next, idx2_reg, idx2_next;
    addr_t             entry2_reg, entry2_next;
    addr_t             best_idx_reg, best_idx_next, best_entry_reg, best_entry_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    addr_t             cur_reg, cur_next;
    logic [COST_W-1:0] cur_cost_reg, cur_cost_next;
    logic [1:0]        k_reg, k_next;

    logic              res_found_reg, res_found_next;
    logic [7:0]        res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [COST_W-1:0] res_cost_reg, res_cost_next;
    dir_t              res_parent_reg, res_parent_next;
    logic              res_vis_reg, res_vis_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [7:0]        out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    dir_t              out_parent_reg, out_parent_next;
    logic              out_vis_reg, out_vis_next;

    // ---------------- shared step / distance unit ----------------
    // Used by the nearest-free resolution (ring of eight) and by expansion (four steps).
    logic       nb_phase;
    gx_t        su_bx, su_tx;
    gy_t        su_by, su_ty;
    logic [2:0] su_dir;
    step_t      su;

    always_comb
    begin
        nb_phase = (state_reg == ST_NB_ISSUE) || (state_reg == ST_NB_CHECK);
        if (nb_phase)
        begin
            su_bx  = cur_reg[XW-1:0];
            su_by  = cur_reg[AW-1:XW];
            su_tx  = gx_reg;
            su_ty  = gy_reg;
            su_dir = {1'b0, k_reg};
        end
        else if (pass_reg)
        begin
            su_bx  = gx_reg;
            su_by  = gy_reg;
            su_tx  = sx_reg;
            su_ty  = sy_reg;
            su_dir = ring_reg;
        end
        else
        begin
            su_bx  = sx_reg;
            su_by  = sy_reg;
            su_tx  = gx_reg;
            su_ty  = gy_reg;
            su_dir = ring_reg;
        end
    end

    gasp_step_unit u_step (
        .base_x(su_bx), .base_y(su_by), .dir(su_dir),
        .tgt_x(su_tx), .tgt_y(su_ty), .step(su)
    );

    // ---------------- handshake ----------------
    logic req_fire, rsp_fire;
    logic in_bounds, tgt_bounds;
    addr_t req_addr;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    assign in_bounds  = (9'(req.cell_x) < 9'(GRID_WIDTH)) && (9'(req.cell_y) < 9'(GRID_HEIGHT));
    assign tgt_bounds = (9'(req.goal_x) < 9'(GRID_WIDTH))
                     && (9'(req.goal_y) < 9'(GRID_HEIGHT));
    assign req_addr   = {req.cell_y[YW-1:0], req.cell_x[XW-1:0]};

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.resolved_x = out_x_reg;
    assign rsp.resolved_y = out_y_reg;
    assign rsp.cost       = out_cost_reg;
    assign rsp.parent_dir = out_parent_reg;
    assign rsp.visited    = out_vis_reg;

    // ---------------- sequencer ----------------
    logic              ng_ge;
    logic [COST_W:0]   ng;
    logic [PRIO_W-1:0] nf;
    addr_t             s_addr, g_addr, n_addr;
    logic              pass_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            clr_reg       <= '0;
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        best_x_reg     <= best_x_next;
        best_y_reg     <= best_y_next;
        best_d_reg     <= best_d_next;
        have_reg       <= have_next;
        blk_s_reg      <= blk_s_next;
        blk_g_reg      <= blk_g_next;
        ring_reg       <= ring_next;
        si_reg         <= si_next;
        idx1_reg       <= idx1_next;
        idx2_reg       <= idx2_next;
        entry2_reg     <= entry2_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        best_prio_reg  <= best_prio_next;
        cur_reg        <= cur_next;
        cur_cost_reg   <= cur_cost_next;
        k_reg          <= k_next;
        res_found_reg  <= res_found_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_cost_reg   <= res_cost_next;
        res_parent_reg <= res_parent_next;
        res_vis_reg    <= res_vis_next;
        out_found_reg  <= out_found_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_cost_reg   <= out_cost_next;
        out_parent_reg <= out_parent_next;
        out_vis_reg    <= out_vis_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_d_next     = best_d_reg;
        pass_next       = pass_reg;
        have_next       = have_reg;
        blk_s_next      = blk_s_reg;
        blk_g_next      = blk_g_reg;
        ring_next       = ring_reg;
        count_next      = count_reg;
        si_next         = si_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        idx1_next       = idx1_reg;
        idx2_next       = idx1_reg;
        entry2_next     = open_rdata;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        best_prio_next  = best_prio_reg;
        cur_next        = cur_reg;
        cur_cost_next   = cur_cost_reg;
        k_next          = k_reg;
        res_found_next  = res_found_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_cost_next   = res_cost_reg;
        res_parent_next = res_parent_reg;
        res_vis_next    = res_vis_reg;
        out_valid_next  = out_valid_reg && !rsp_fire;
        out_found_next  = out_found_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_cost_next   = out_cost_reg;
        out_parent_next = out_parent_reg;
        out_vis_next    = out_vis_reg;

        obs_we     = 1'b0;
        obs_waddr  = req_addr;
        obs_wdata  = req.obstacle;
        obs_raddr  = {sy_reg, sx_reg};
        cell_we    = 1'b0;
        cell_waddr = clr_reg;
        cell_wdata = '0;
        cell_raddr = req_addr;
        open_we    = 1'b0;
        open_waddr = count_reg[AW-1:0];
        open_wdata = '0;
        open_raddr = si_reg[AW-1:0];

        s_addr       = {sy_reg, sx_reg};
        g_addr       = {gy_reg, gx_reg};
        n_addr       = {su.y, su.x};
        ng           = {1'b0, cur_cost_reg} + (COST_W + 1)'(1);
        nf           = PRIO_W'(ng) + PRIO_W'(su.manh);
        ng_ge        = ng >= {1'b0, cell_rdata.cost};
        pass_blocked = 1'b0;

        unique case (state_reg)
            // power-on sweep: obstacle map free, cell store cleared
            ST_WIPE:
            begin
                obs_we     = 1'b1;
                obs_waddr  = clr_reg;
                obs_wdata  = 1'b0;
                cell_we    = 1'b1;
                clr_next   = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_fire)
                begin
                    res_found_next  = 1'b0;
                    res_x_next      = req.cell_x;
                    res_y_next      = req.cell_y;
                    res_cost_next   = '0;
                    res_parent_next = DIR_NONE;
                    res_vis_next    = 1'b0;
                    state_next      = ST_DONE;
                    case (mode_t'(req.mode))
                        MODE_SET:
                        begin
                            obs_we         = in_bounds;
                            res_found_next = in_bounds;
                        end
                        MODE_READ:
                        begin
                            if (in_bounds)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            res_x_next = req.goal_x;
                            res_y_next = req.goal_y;
                            sx_next    = req.cell_x[XW-1:0];
                            sy_next    = req.cell_y[YW-1:0];
                            gx_next    = req.goal_x[XW-1:0];
                            gy_next    = req.goal_y[YW-1:0];
                            if (in_bounds && tgt_bounds)
                            begin
                                clr_next   = '0;
                                state_next = ST_CLEAR;
                            end
                        end
                        default:
                        begin
                            res_x_next = '0;
                            res_y_next = '0;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_found_next  = 1'b1;
                res_cost_next   = cell_rdata.cost;
                res_parent_next = cell_rdata.parent;
                res_vis_next    = cell_rdata.visited;
                state_next      = ST_DONE;
            end

            ST_CLEAR:
            begin
                cell_we  = 1'b1;
                clr_next = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(DEPTH - 1))
                begin
                    pass_next  = 1'b0;
                    state_next = ST_NF_C;
                end
            end

            // nearest free ring cell; pass 0 moves the start, pass 1 the goal
            ST_NF_C:
            begin
                obs_raddr  = pass_reg ? g_addr : s_addr;
                state_next = ST_NF_CW;
            end

            ST_NF_CW:
            begin
                if (!obs_rdata)
                begin
                    if (pass_reg)
                    begin
                        blk_g_next = 1'b0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        blk_s_next = 1'b0;
                        pass_next  = 1'b1;
                        state_next = ST_NF_C;
                    end
                end
                else
                begin
                    ring_next  = '0;
                    have_next  = 1'b0;
                    state_next = ST_NF_R;
                end
            end

            ST_NF_R:
            begin
                obs_raddr = n_addr;
                if (su.ok)
                begin
                    state_next = ST_NF_RW;
                end
                else if (ring_reg == 3'd7)
                begin
                    state_next = ST_NF_END;
                end
                else
                begin
                    ring_next = ring_reg + 3'd1;
                end
            end

            ST_NF_RW:
            begin
                if (!obs_rdata && (!have_reg || su.manh < best_d_reg))
                begin
                    have_next   = 1'b1;
                    best_x_next = su.x;
                    best_y_next = su.y;
                    best_d_next = su.manh;
                end
                ring_next  = ring_reg + 3'd1;
                state_next = (ring_reg == 3'd7) ? ST_NF_END : ST_NF_R;
            end

            ST_NF_END:
            begin
                pass_blocked = !have_reg;
                if (pass_reg)
                begin
                    blk_g_next = pass_blocked;
                    if (have_reg)
                    begin
                        gx_next = best_x_reg;
                        gy_next = best_y_reg;
                    end
                    state_next = ST_CHECK;
                end
                else
                begin
                    blk_s_next = pass_blocked;
                    if (have_reg)
                    begin
                        sx_next = best_x_reg;
                        sy_next = best_y_reg;
                    end
                    pass_next  = 1'b1;
                    state_next = ST_NF_C;
                end
            end

            ST_CHECK:
            begin
                res_x_next = 8'(gx_reg);
                res_y_next = 8'(gy_reg);
                if (blk_s_reg || blk_g_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (s_addr == g_addr)
                begin
                    // start on goal: success with no expansion
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end

            ST_INIT:
            begin
                open_we         = 1'b1;
                open_waddr      = '0;
                open_wdata      = s_addr;
                cell_we         = 1'b1;
                cell_waddr      = s_addr;
                cell_wdata      = '0;
                cell_wdata.open = 1'b1;
                count_next      = CW'(1);
                si_next         = '0;
                state_next      = ST_SCAN;
            end

            // linear scan: open-list read, then cell read, then compare
            ST_SCAN:
            begin
                cell_raddr = open_rdata;
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (si_reg < count_reg)
                    begin
                        v1_next   = 1'b1;
                        idx1_next = si_reg[AW-1:0];
                        si_next   = si_reg + CW'(1);
                    end
                    v2_next = v1_reg;
                    if (v2_reg && (idx2_reg == '0 || cell_rdata.prio < best_prio_reg))
                    begin
                        best_idx_next   = idx2_reg;
                        best_entry_next = entry2_reg;
                        best_prio_next  = cell_rdata.prio;
                    end
                    if (si_reg == count_reg && !v1_reg && !v2_reg)
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end

            ST_POP_RD:
            begin
                count_next = count_reg - CW'(1);
                open_raddr = count_next[AW-1:0];
                cell_raddr = best_entry_reg;
                state_next = ST_POP_WR;
            end

            ST_POP_WR:
            begin
                // last entry fills the hole
                open_we            = {1'b0, best_idx_reg} < count_reg;
                open_waddr         = best_idx_reg;
                open_wdata         = open_rdata;
                cell_we            = 1'b1;
                cell_waddr         = best_entry_reg;
                cell_wdata         = cell_rdata;
                cell_wdata.open    = 1'b0;
                cell_wdata.visited = 1'b1;
                cur_next           = best_entry_reg;
                cur_cost_next      = cell_rdata.cost;
                k_next             = '0;
                if (best_entry_reg == g_addr)
                begin
                    res_found_next  = 1'b1;
                    res_cost_next   = cell_rdata.cost;
                    res_parent_next = cell_rdata.parent;
                    res_vis_next    = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_NB_ISSUE;
                end
            end

            ST_NB_ISSUE:
            begin
                obs_raddr  = n_addr;
                cell_raddr = n_addr;
                if (su.ok)
                begin
                    state_next = ST_NB_CHECK;
                end
                else if (k_reg == 2'd3)
                begin
                    si_next    = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            ST_NB_CHECK:
            begin
                if (!obs_rdata && !cell_rdata.visited && !(cell_rdata.open && ng_ge))
                begin
                    cell_we           = 1'b1;
                    cell_waddr        = n_addr;
                    cell_wdata.cost   = ng[COST_W-1:0];
                    cell_wdata.prio   = nf;
                    cell_wdata.parent = back_dir(k_reg);
                    cell_wdata.open   = 1'b1;
                    cell_wdata.visited = 1'b0;
                    if (!cell_rdata.open)
                    begin
                        open_we    = 1'b1;
                        open_waddr = count_reg[AW-1:0];
                        open_wdata = n_addr;
                        count_next = count_reg + CW'(1);
                    end
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    si_next    = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_NB_ISSUE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    out_cost_next   = res_cost_reg;
                    out_parent_next = res_parent_reg;
                    out_vis_next    = res_vis_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // open list can never hold more than the grid
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("open list count out of range");

    // a pop only happens with a non-empty open list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP_RD |-> count_reg != '0)
        else $error("pop from empty open list");

    // every accepted item leaves idle on the next cycle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != ST_IDLE)
        else $error("accepted item did not start");

    // a result is loaded only from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared outside done state");
`endif

endmodule

/* rtl/gasp_ram.sv */
`timescale 1ns / 1ps

module gasp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/gasp_step_unit.sv */
`timescale 1ns / 1ps

module gasp_step_unit
    import gasp_pkg::*;
(
    input  gx_t        base_x,
    input  gy_t        base_y,
    input  logic [2:0] dir,
    input  gx_t        tgt_x,
    input  gy_t        tgt_y,
    output step_t      step
);

    logic [1:0] dx;
    logic [1:0] dy;
    gx_t        nx;
    gy_t        ny;
    gx_t        ax;
    gy_t        ay;
    logic       xo;
    logic       yo;

    always_comb
    begin
        dx = ring_dx(dir);
        dy = ring_dy(dir);
        xo = (dx[1] && base_x == '0) || (dx[0] && base_x == gx_t'(GRID_WIDTH - 1));
        yo = (dy[1] && base_y == '0) || (dy[0] && base_y == gy_t'(GRID_HEIGHT - 1));
        nx = dx[1] ? base_x - gx_t'(1) : (dx[0] ? base_x + gx_t'(1) : base_x);
        ny = dy[1] ? base_y - gy_t'(1) : (dy[0] ? base_y + gy_t'(1) : base_y);
        ax = (nx >= tgt_x) ? nx - tgt_x : tgt_x - nx;
        ay = (ny >= tgt_y) ? ny - tgt_y : tgt_y - ny;
        step.ok   = !xo && !yo;
        step.x    = nx;
        step.y    = ny;
        step.manh = DW'(ax) + DW'(ay);
    end

endmodule

/* tb/grid_astar_path_search_unit_test.sv */
`timescale 1ns / 1ps

module grid_astar_path_search_unit_test;
    import gasp_pkg::*;

    // Cycles with no item moving on either side before the run is called hung. A search on an
    // open 32x32 grid with a long open list stays well below this.
    localparam int STALL_LIMIT = 600000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic        found;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [11:0] cost;
        logic [2:0]  dir;
        logic        visited;
    } path_result_t;

    // Scoreboard: keeps its own copy of the grid and cell store, predicts
    // each result when a request is accepted and checks results in order.
    class path_scoreboard;
        bit          blocked[DEPTH];
        logic [11:0] g_cost[DEPTH];
        logic [12:0] f_prio[DEPTH];
        dir_t        parent[DEPTH];
        bit          expanded[DEPTH];
        bit          queued[DEPTH];
        int          frontier[DEPTH];
        int          frontier_len;
        int          step_dx[4] = '{0, 0, -1, 1};
        int          step_dy[4] = '{-1, 1, 0, 0};
        dir_t        back_side[4] = '{DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};
        int          ring_dx[8] = '{0, 0, -1, 1, -1, 1, -1, 1};
        int          ring_dy[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
        path_result_t expected_q[$];
        int          mismatches;
        int          last_gx;
        int          last_gy;
        bit          last_found;

        function new();
            foreach (blocked[i])
                blocked[i] = 0;
            frontier_len = 0;
            mismatches = 0;
            wipe_cells();
        endfunction

        function void wipe_cells();
            foreach (g_cost[i])
            begin
                g_cost[i] = '0;
                f_prio[i] = '0;
                parent[i] = DIR_NONE;
                expanded[i] = 0;
                queued[i] = 0;
            end
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT;
        endfunction

        function int abs_diff(int a, int b);
            return a > b ? a - b : b - a;
        endfunction

        // a blocked endpoint moves to its free 8-neighbor nearest the other end
        function void relocate(inout int x, inout int y, input int tx, input int ty);
            int bx;
            int by;
            int best;
            int nx;
            int ny;
            int d;
            bx = x;
            by = y;
            best = 32'h7fffffff;
            if (!blocked[y * GRID_WIDTH + x])
                return;
            for (int i = 0; i < 8; i++)
            begin
                nx = x + ring_dx[i];
                ny = y + ring_dy[i];
                if (on_grid(nx, ny) && !blocked[ny * GRID_WIDTH + nx])
                begin
                    d = abs_diff(nx, tx) + abs_diff(ny, ty);
                    if (d < best)
                    begin
                        best = d;
                        bx = nx;
                        by = ny;
                    end
                end
            end
            x = bx;
            y = by;
        endfunction

        function bit run_search(int sx, int sy, int gx, int gy);
            int s;
            int g;
            int pick;
            int cur;
            int cx;
            int cy;
            int nx;
            int ny;
            int c;
            int unsigned ng;
            int unsigned nh;
            s = sy * GRID_WIDTH + sx;
            g = gy * GRID_WIDTH + gx;
            if (s == g)
                return 1;
            frontier_len = 0;
            frontier[frontier_len++] = s;
            queued[s] = 1;
            while (frontier_len > 0)
            begin
                pick = 0;
                for (int i = 1; i < frontier_len; i++)
                    if (f_prio[frontier[i]] < f_prio[frontier[pick]])
                        pick = i;
                cur = frontier[pick];
                queued[cur] = 0;
                frontier_len--;
                if (pick < frontier_len)
                    frontier[pick] = frontier[frontier_len];
                expanded[cur] = 1;
                if (cur == g)
                    return 1;
                cx = cur % GRID_WIDTH;
                cy = cur / GRID_WIDTH;
                for (int k = 0; k < 4; k++)
                begin
                    nx = cx + step_dx[k];
                    ny = cy + step_dy[k];
                    if (!on_grid(nx, ny))
                        continue;
                    c = ny * GRID_WIDTH + nx;
                    if (blocked[c] || expanded[c])
                        continue;
                    ng = g_cost[cur] + 1;
                    nh = abs_diff(nx, gx) + abs_diff(ny, gy);
                    if (queued[c] && ng >= g_cost[c])
                        continue;
                    g_cost[c] = ng[11:0];
                    f_prio[c] = 13'(ng + nh);
                    parent[c] = back_side[k];
                    if (!queued[c])
                    begin
                        frontier[frontier_len++] = c;
                        queued[c] = 1;
                    end
                end
            end
            return 0;
        endfunction

        function void note_request(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                                   logic [7:0] tx, logic [7:0] ty, logic ob);
            path_result_t r;
            int sx;
            int sy;
            int gx;
            int gy;
            int c;
            bit ok;
            r = '{1'b0, 8'd0, 8'd0, 12'd0, 3'd0, 1'b0};
            sx = x;
            sy = y;
            gx = tx;
            gy = ty;
            last_found = 0;
            if (mode == MODE_SET)
            begin
                r.rx = x;
                r.ry = y;
                if (on_grid(sx, sy))
                begin
                    blocked[sy * GRID_WIDTH + sx] = ob;
                    r.found = 1;
                end
            end
            else if (mode == MODE_READ)
            begin
                r.rx = x;
                r.ry = y;
                if (on_grid(sx, sy))
                begin
                    c = sy * GRID_WIDTH + sx;
                    r.found = 1;
                    r.cost = g_cost[c];
                    r.dir = parent[c];
                    r.visited = expanded[c];
                end
            end
            else if (mode == MODE_SEARCH)
            begin
                r.rx = tx;
                r.ry = ty;
                if (on_grid(sx, sy) && on_grid(gx, gy))
                begin
                    wipe_cells();
                    relocate(sx, sy, gx, gy);
                    relocate(gx, gy, sx, sy);
                    r.rx = gx[7:0];
                    r.ry = gy[7:0];
                    c = gy * GRID_WIDTH + gx;
                    ok = !blocked[sy * GRID_WIDTH + sx] && !blocked[c] &&
                         run_search(sx, sy, gx, gy);
                    r.found = ok;
                    r.cost = ok ? g_cost[c] : 12'd0;
                    r.dir = parent[c];
                    r.visited = expanded[c];
                    last_found = ok;
                    last_gx = gx;
                    last_gy = gy;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        endfunction

        function void check_result(path_result_t got);
            path_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result with nothing pending, found", got.found, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found)
                report("found", got.found, want.found);
            if (got.rx !== want.rx)
                report("resolved_x", got.rx, want.rx);
            if (got.ry !== want.ry)
                report("resolved_y", got.ry, want.ry);
            if (got.cost !== want.cost)
                report("cost", got.cost, want.cost);
            if (got.dir !== want.dir)
                report("parent_dir", got.dir, want.dir);
            if (got.visited !== want.visited)
                report("visited", got.visited, want.visited);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    gasp_req_if req_bus ();
    gasp_rsp_if rsp_bus ();

    grid_astar_path_search_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    path_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_pending = 0;
    int  quiet_cycles = 0;

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 0;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Results are sampled at the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        path_result_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.found = rsp_bus.found;
            got.rx = rsp_bus.resolved_x;
            got.ry = rsp_bus.resolved_y;
            got.cost = rsp_bus.cost;
            got.dir = rsp_bus.parent_dir;
            got.visited = rsp_bus.visited;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request, hold it until accepted, then maybe leave a gap.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_request(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                                logic [7:0] tx, logic [7:0] ty, logic ob);
        req_bus.valid <= 1'b1;
        req_bus.mode <= mode;
        req_bus.cell_x <= x;
        req_bus.cell_y <= y;
        req_bus.goal_x <= tx;
        req_bus.goal_y <= ty;
        req_bus.obstacle <= ob;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(mode, x, y, tx, ty, ob);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        // a write may still be landing after its result went out
        repeat (8) @(posedge clk);
    endtask

    // After a successful search, read the goal and follow parents a few steps.
    task automatic walk_parents(int n);
        int cx;
        int cy;
        int c;
        if (!sb.last_found)
            return;
        cx = sb.last_gx;
        cy = sb.last_gy;
        for (int k = 0; k < n; k++)
        begin
            send_request(MODE_READ, cx[7:0], cy[7:0], 8'($urandom), 8'($urandom),
                         1'($urandom));
            c = cy * GRID_WIDTH + cx;
            case (sb.parent[c])
                DIR_UP:    cy--;
                DIR_DOWN:  cy++;
                DIR_LEFT:  cx--;
                DIR_RIGHT: cx++;
                default:   return;
            endcase
        end
    endtask

    function automatic logic [7:0] near_coord();
        // mostly a small corner region, sometimes the whole grid, rarely off it
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return 8'($urandom_range(11));
        else if (r < 95)
            return 8'($urandom_range(GRID_WIDTH - 1));
        return 8'($urandom);
    endfunction

    task automatic random_phase(int n);
        int r;
        int k;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                send_request(MODE_SET, near_coord(), near_coord(), 8'($urandom),
                             8'($urandom), ($urandom_range(99) < 70));
                k++;
            end
            else if (r < 65)
            begin
                send_request(MODE_SEARCH, near_coord(), near_coord(), near_coord(),
                             near_coord(), 1'($urandom));
                walk_parents($urandom_range(1, 4));
                k += 3;
            end
            else if (r < 90)
            begin
                send_request(MODE_READ, near_coord(), near_coord(), 8'($urandom),
                             8'($urandom), 1'($urandom));
                k++;
            end
            else
            begin
                send_request(MODE_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom));
                k++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode = MODE_SET;
        req_bus.cell_x = '0;
        req_bus.cell_y = '0;
        req_bus.goal_x = '0;
        req_bus.goal_y = '0;
        req_bus.obstacle = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 7;
        rx_idle_pct = 49;

        // Directed part.
        // open-grid search corner to corner, then the far corner cell
        send_request(MODE_SEARCH, 8'd0, 8'd0, 8'd31, 8'd31, 1'b0);
        send_request(MODE_READ, 8'd31, 8'd31, 8'hff, 8'hff, 1'b1);
        // start equals goal
        send_request(MODE_SEARCH, 8'd7, 8'd9, 8'd7, 8'd9, 1'b1);
        // searches with start or goal off the grid
        send_request(MODE_SEARCH, 8'd32, 8'd3, 8'd1, 8'd1, 1'b0);
        send_request(MODE_SEARCH, 8'd3, 8'd3, 8'd200, 8'd255, 1'b0);
        // writes and reads off the grid, and the unused mode
        send_request(MODE_SET, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
        send_request(MODE_READ, 8'd5, 8'd128, 8'd0, 8'd0, 1'b0);
        send_request(MODE_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
        // fence the corner: start blocked with no free neighbor
        send_request(MODE_SET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_request(MODE_SET, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1);
        send_request(MODE_SET, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1);
        send_request(MODE_SET, 8'd1, 8'd1, 8'd0, 8'd0, 1'b1);
        send_request(MODE_SEARCH, 8'd0, 8'd0, 8'd5, 8'd5, 1'b0);
        // corner free but walled in: no path
        send_request(MODE_SET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_request(MODE_SEARCH, 8'd0, 8'd0, 8'd5, 8'd5, 1'b0);
        send_request(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        // blocked goal moved to a free neighbor, blocked start moved too
        send_request(MODE_SEARCH, 8'd6, 8'd6, 8'd1, 8'd1, 1'b0);
        send_request(MODE_SEARCH, 8'd1, 8'd0, 8'd8, 8'd2, 1'b0);
        walk_parents(3);
        send_request(MODE_SET, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        send_request(MODE_SET, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0);
        send_request(MODE_SET, 8'd1, 8'd1, 8'd0, 8'd0, 1'b0);

        random_phase(50);
        drain();

        tx_idle_pct = 49;
        rx_idle_pct = 7;
        random_phase(45);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long result hold-off while requests keep coming, so the input stalls
        hold_pending = 1;
        random_phase(45);
        drain();

        repeat (50) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report("results still pending", sb.expected_q.size(), 0);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
